/* hw/rtl/gjk_pkg.sv */
// Shared widths, types and codes for the GJK simplex update block.
package gjk_pkg;

  localparam int PT_W   = 16;          // point coordinate width
  localparam int DF_W   = PT_W + 1;    // point difference width
  localparam int DIR_W  = 54;          // search direction width
  localparam int PROD_W = DIR_W + DF_W;
  localparam int ACC_W  = PROD_W + 1;
  localparam int MAX_PTS = 4;

  localparam int IN_DATA_W  = 216;     // 3 * PT_W + 3 * DIR_W, padded to bytes
  localparam int OUT_DATA_W = 168;     // 3 * DIR_W + 3, padded to bytes

  localparam logic OP_CLEAR = 1'b0;
  localparam logic OP_PUSH  = 1'b1;

  typedef logic [2:0][PT_W-1:0]  pvec_t;
  typedef logic [2:0][DF_W-1:0]  nvec_t;
  typedef logic [2:0][DIR_W-1:0] wvec_t;

  // Wide operand sources of the shared multiplier
  typedef enum logic [2:0] {
    WS_AB, WS_AC, WS_AD, WS_A0, WS_T1, WS_T2
  } wsrc_t;

  // Narrow operand sources of the shared multiplier
  typedef enum logic [1:0] {
    NS_AB, NS_AC, NS_AD, NS_A0
  } nsrc_t;

  // Destination of a cross product
  typedef enum logic [1:0] {
    DS_T1, DS_T2, DS_DIR
  } dsrc_t;

endpackage

/* hw/rtl/gjk_simplex_update.sv */
// GJK 3D simplex step around one shared multiply-accumulate unit.
// A clear goes straight to the finish state and the output register; a push
// runs the cross products and dot tests that its simplex case needs through
// the single multiplier.
// Throughput: one request at a time; the input is ready only while idle.
// Reset: simplex emptied (count zero, points zero), no result pending.
module gjk_simplex_update
  import gjk_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // point_x, point_y, point_z, prior_dir_x, prior_dir_y, prior_dir_z
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // op
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // next_dir_x, next_dir_y, next_dir_z, simplex_count
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // contains_origin
  output logic                  m_axis_tuser
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_START, ST_LINE_DOT, ST_LINE_X1, ST_LINE_X2,
    ST_TRI_ABC, ST_TRI_X, ST_TRI_D1, ST_TRI_D2, ST_TRI_Y, ST_TRI_D3, ST_TRI_D4,
    ST_TET_1, ST_TET_D1, ST_TET_2, ST_TET_D2, ST_TET_3, ST_TET_D3, ST_FINISH
  } state_t;

  state_t state;

  pvec_t pa, pb, pc, pd;
  logic [2:0] cnt;
  wvec_t t1, t2, dirv;
  logic enclosed;

  logic [2:0] stp;
  logic signed [PROD_W-1:0] prod;
  logic [2:0] p_idx;
  logic p_val;
  logic signed [ACC_W-1:0] acc;

  logic [DIR_W-1:0] o_dx, o_dy, o_dz;
  logic [2:0] o_cnt;
  logic o_in;

  nvec_t ab, ac, ad, a0;
  wvec_t wsel;
  nvec_t nsel;

  logic j_act, j_cross, j_neg;
  wsrc_t j_w;
  nsrc_t j_n;
  dsrc_t j_dest;
  logic [2:0] last;
  logic issue, done;
  logic [1:0] m_comp, wi, ni, p_comp;
  logic p_half, p_first;
  logic signed [PROD_W-1:0] mul;
  logic signed [ACC_W-1:0] pext, sum_next, res;
  logic face;
  logic [2:0] cnt_inc;

  function automatic logic [1:0] nx(input logic [1:0] c);
    return (c == 2'd2) ? 2'd0 : c + 2'd1;
  endfunction

  // Form edge vectors from the stored points
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ab[k] = {pb[k][PT_W-1], pb[k]} - {pa[k][PT_W-1], pa[k]};
      ac[k] = {pc[k][PT_W-1], pc[k]} - {pa[k][PT_W-1], pa[k]};
      ad[k] = {pd[k][PT_W-1], pd[k]} - {pa[k][PT_W-1], pa[k]};
      a0[k] = DF_W'(0) - {pa[k][PT_W-1], pa[k]};
    end
  end

  // Decode the job that the current state runs
  always_comb begin
    j_act = 1'b1; j_cross = 1'b0; j_neg = 1'b0;
    j_w = WS_AB; j_n = NS_A0; j_dest = DS_T1;
    unique case (state)
      ST_LINE_DOT: begin j_w = WS_AB; j_n = NS_A0; end
      ST_TRI_D1, ST_TRI_D3: begin j_w = WS_T2; j_n = NS_A0; end
      ST_TRI_D2: begin j_w = WS_AC; j_n = NS_A0; end
      ST_TRI_D4, ST_TET_D1, ST_TET_D2, ST_TET_D3: begin j_w = WS_T1; j_n = NS_A0; end
      ST_LINE_X1: begin j_cross = 1'b1; j_w = WS_AB; j_n = NS_A0; j_dest = DS_T1; end
      ST_LINE_X2: begin
        j_cross = 1'b1; j_w = WS_T1; j_n = NS_AB; j_neg = 1'b1; j_dest = DS_DIR;
      end
      ST_TRI_ABC, ST_TET_1: begin j_cross = 1'b1; j_w = WS_AB; j_n = NS_AC; end
      ST_TRI_X: begin j_cross = 1'b1; j_w = WS_T1; j_n = NS_AC; j_dest = DS_T2; end
      ST_TRI_Y: begin
        j_cross = 1'b1; j_w = WS_T1; j_n = NS_AB; j_neg = 1'b1; j_dest = DS_T2;
      end
      ST_TET_2: begin j_cross = 1'b1; j_w = WS_AC; j_n = NS_AD; end
      ST_TET_3: begin j_cross = 1'b1; j_w = WS_AD; j_n = NS_AB; end
      default: j_act = 1'b0;
    endcase
  end

  // Select multiplier operands
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      case (j_w)
        WS_AB:   wsel[k] = {{(DIR_W-DF_W){ab[k][DF_W-1]}}, ab[k]};
        WS_AC:   wsel[k] = {{(DIR_W-DF_W){ac[k][DF_W-1]}}, ac[k]};
        WS_AD:   wsel[k] = {{(DIR_W-DF_W){ad[k][DF_W-1]}}, ad[k]};
        WS_A0:   wsel[k] = {{(DIR_W-DF_W){a0[k][DF_W-1]}}, a0[k]};
        WS_T1:   wsel[k] = t1[k];
        default: wsel[k] = t2[k];
      endcase
      case (j_n)
        NS_AB:   nsel[k] = ab[k];
        NS_AC:   nsel[k] = ac[k];
        NS_AD:   nsel[k] = ad[k];
        default: nsel[k] = a0[k];
      endcase
    end
  end

  // Issue one product per cycle; cross components take two products
  assign last   = j_cross ? 3'd5 : 3'd2;
  assign issue  = j_act && (stp <= last);
  assign m_comp = j_cross ? stp[2:1] : stp[1:0];
  always_comb begin
    if (!j_cross) begin
      wi = m_comp; ni = m_comp;
    end else if (!stp[0]) begin
      wi = nx(m_comp); ni = nx(nx(m_comp));
    end else begin
      wi = nx(nx(m_comp)); ni = nx(m_comp);
    end
  end
  assign mul = $signed(wsel[wi]) * $signed(nsel[ni]);

  // Accumulate the registered product
  assign p_comp   = j_cross ? p_idx[2:1] : p_idx[1:0];
  assign p_half   = j_cross & p_idx[0];
  assign p_first  = j_cross ? !p_idx[0] : (p_idx == 3'd0);
  assign pext     = {prod[PROD_W-1], prod};
  assign sum_next = p_first ? pext : (p_half ? acc - pext : acc + pext);
  assign res      = j_neg ? -sum_next : sum_next;
  assign face     = !sum_next[ACC_W-1] && (sum_next != '0);
  assign done     = p_val && (p_idx == last);
  assign cnt_inc  = (cnt >= 3'(MAX_PTS)) ? 3'(MAX_PTS) : cnt + 3'd1;

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tdata  = {3'd0, o_cnt, o_dz, o_dy, o_dx};
  assign m_axis_tuser  = o_in;

  // Sequencer, datapath registers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt <= '0;
      pa <= '0; pb <= '0; pc <= '0; pd <= '0;
      stp <= '0;
      p_val <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != ST_FINISH)) m_axis_tvalid <= 1'b0;

      // Advance the multiply pipeline
      p_val <= issue;
      p_idx <= stp;
      prod  <= mul;
      if (done) stp <= '0;
      else if (issue) stp <= stp + 3'd1;
      if (p_val) begin
        acc <= sum_next;
        if (j_cross && p_half) begin
          case (j_dest)
            DS_T1:   t1[p_comp]   <= res[DIR_W-1:0];
            DS_T2:   t2[p_comp]   <= res[DIR_W-1:0];
            default: dirv[p_comp] <= res[DIR_W-1:0];
          endcase
        end
      end

      unique case (state)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            enclosed <= 1'b0;
            if (s_axis_tuser == OP_CLEAR) begin
              pa <= '0; pb <= '0; pc <= '0; pd <= '0;
              cnt <= '0;
              dirv <= '0;
              state <= ST_FINISH;
            end else begin
              pa <= s_axis_tdata[3*PT_W-1:0];
              pb <= pa; pc <= pb; pd <= pc;
              cnt <= cnt_inc;
              for (int k = 0; k < 3; k++)
                dirv[k] <= s_axis_tdata[3*PT_W + k*DIR_W +: DIR_W];
              state <= ST_START;
            end
          end
        end
        ST_START: begin
          stp <= '0;
          unique case (cnt)
            3'd2:    state <= ST_LINE_DOT;
            3'd3:    state <= ST_TRI_ABC;
            3'd4:    state <= ST_TET_1;
            default: state <= ST_FINISH;
          endcase
        end
        ST_LINE_DOT: if (done) begin
          if (face) state <= ST_LINE_X1;
          else begin
            cnt <= 3'd1;
            for (int k = 0; k < 3; k++)
              dirv[k] <= {{(DIR_W-DF_W){a0[k][DF_W-1]}}, a0[k]};
            state <= ST_FINISH;
          end
        end
        ST_LINE_X1: if (done) state <= ST_LINE_X2;
        ST_LINE_X2: if (done) state <= ST_FINISH;
        ST_TRI_ABC: if (done) state <= ST_TRI_X;
        ST_TRI_X:   if (done) state <= ST_TRI_D1;
        ST_TRI_D1:  if (done) state <= face ? ST_TRI_D2 : ST_TRI_Y;
        ST_TRI_D2: if (done) begin
          cnt <= 3'd2;
          if (face) begin
            pb <= pc;
            state <= ST_LINE_X1;
          end else state <= ST_LINE_DOT;
        end
        ST_TRI_Y: if (done) state <= ST_TRI_D3;
        ST_TRI_D3: if (done) begin
          if (face) begin
            cnt <= 3'd2;
            state <= ST_LINE_DOT;
          end else state <= ST_TRI_D4;
        end
        ST_TRI_D4: if (done) begin
          if (face) dirv <= t1;
          else begin
            pb <= pc; pc <= pb;
            for (int k = 0; k < 3; k++) dirv[k] <= DIR_W'(0) - t1[k];
          end
          state <= ST_FINISH;
        end
        ST_TET_1: if (done) state <= ST_TET_D1;
        ST_TET_D1: if (done) begin
          if (face) begin
            cnt <= 3'd3;
            state <= ST_TRI_ABC;
          end else state <= ST_TET_2;
        end
        ST_TET_2: if (done) state <= ST_TET_D2;
        ST_TET_D2: if (done) begin
          if (face) begin
            pb <= pc; pc <= pd;
            cnt <= 3'd3;
            state <= ST_TRI_ABC;
          end else state <= ST_TET_3;
        end
        ST_TET_3: if (done) state <= ST_TET_D3;
        ST_TET_D3: if (done) begin
          if (face) begin
            pb <= pd; pc <= pb;
            cnt <= 3'd3;
            state <= ST_TRI_ABC;
          end else begin
            enclosed <= 1'b1;
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // Hold the result until the output register is free
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            o_dx  <= dirv[0];
            o_dy  <= dirv[1];
            o_dz  <= dirv[2];
            o_cnt <= cnt;
            o_in  <= enclosed;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= 3'(MAX_PTS))
    else $error("simplex count above four");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_axis_tready |-> (stp == 3'd0) && !p_val)
    else $error("input ready while the multiplier is busy");

  a_inside_full: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (o_cnt == 3'(MAX_PTS)))
    else $error("origin enclosed without a full tetrahedron");

  a_done_in_job: assert property (@(posedge clk) disable iff (rst)
    p_val |-> j_act)
    else $error("product pending outside a job");

endmodule

/* dv/gjk_simplex_update_chk.sv */
// Checker for the GJK simplex update block: predicts each result and compares it.
`timescale 1ns / 1ps

module gjk_simplex_update_chk
  import gjk_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  m_axis_tuser,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    logic signed [63:0] x;
    logic signed [63:0] y;
    logic signed [63:0] z;
  } vec_t;

  typedef struct packed {
    logic        enclosed;
    logic [53:0] dx;
    logic [53:0] dy;
    logic [53:0] dz;
    logic [2:0]  cnt;
  } step_t;

  // simplex copy, newest point first
  logic signed [15:0] sx [4];
  logic signed [15:0] sy [4];
  logic signed [15:0] sz [4];
  logic [2:0]         npts;
  step_t              step_q [$];

  assign pending = step_q.size();

  function automatic vec_t corner(int i);
    vec_t r;
    r.x = sx[i];
    r.y = sy[i];
    r.z = sz[i];
    return r;
  endfunction

  function automatic vec_t vsub(vec_t a, vec_t b);
    vec_t r;
    r.x = a.x - b.x;
    r.y = a.y - b.y;
    r.z = a.z - b.z;
    return r;
  endfunction

  function automatic vec_t vneg(vec_t a);
    vec_t r;
    r.x = -a.x;
    r.y = -a.y;
    r.z = -a.z;
    return r;
  endfunction

  function automatic vec_t vcross(vec_t a, vec_t b);
    vec_t r;
    r.x = a.y * b.z - a.z * b.y;
    r.y = a.z * b.x - a.x * b.z;
    r.z = a.x * b.y - a.y * b.x;
    return r;
  endfunction

  // strictly positive dot product, exact in 128 bits
  function automatic bit faces(vec_t u, vec_t w);
    logic signed [127:0] ux, uy, uz, wx, wy, wz, s;
    ux = u.x; uy = u.y; uz = u.z;
    wx = w.x; wy = w.y; wz = w.z;
    s = ux * wx + uy * wy + uz * wz;
    return s > 0;
  endfunction

  function automatic logic [53:0] clamp_dir(logic signed [63:0] v);
    logic signed [63:0] lim;
    lim = 64'sd1 <<< 52;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    return v[53:0];
  endfunction

  task automatic store(int i, vec_t p);
    sx[i] = p.x[15:0];
    sy[i] = p.y[15:0];
    sz[i] = p.z[15:0];
  endtask

  task automatic line_case(output vec_t d);
    vec_t a, ab, a0;
    a  = corner(0);
    ab = vsub(corner(1), a);
    a0 = vneg(a);
    if (faces(ab, a0)) begin
      d = vcross(ab, vcross(ab, a0));
    end else begin
      npts = 1;
      d = a0;
    end
  endtask

  task automatic triangle_case(output vec_t d);
    vec_t a, b, c, ab, ac, a0, abc;
    a = corner(0); b = corner(1); c = corner(2);
    ab = vsub(b, a); ac = vsub(c, a); a0 = vneg(a);
    abc = vcross(ab, ac);
    if (faces(vcross(abc, ac), a0)) begin
      npts = 2;
      if (faces(ac, a0)) begin
        store(1, c);
        d = vcross(ac, vcross(ac, a0));
      end else begin
        line_case(d);
      end
    end else if (faces(vcross(ab, abc), a0)) begin
      npts = 2;
      line_case(d);
    end else if (faces(abc, a0)) begin
      d = abc;
    end else begin
      store(1, c);
      store(2, b);
      d = vneg(abc);
    end
  endtask

  task automatic tetra_case(output bit enclosed, inout vec_t d);
    vec_t a, b, c, dd, ab, ac, ad, a0;
    a = corner(0); b = corner(1); c = corner(2); dd = corner(3);
    ab = vsub(b, a); ac = vsub(c, a); ad = vsub(dd, a); a0 = vneg(a);
    enclosed = 0;
    if (faces(vcross(ab, ac), a0)) begin
      npts = 3;
      triangle_case(d);
    end else if (faces(vcross(ac, ad), a0)) begin
      store(1, c);
      store(2, dd);
      npts = 3;
      triangle_case(d);
    end else if (faces(vcross(ad, ab), a0)) begin
      store(1, dd);
      store(2, b);
      npts = 3;
      triangle_case(d);
    end else begin
      enclosed = 1;
    end
  endtask

  function automatic void empty_simplex();
    for (int i = 0; i < 4; i++) begin
      sx[i] = '0; sy[i] = '0; sz[i] = '0;
    end
    npts = 0;
  endfunction

  // advance the simplex copy by one request and queue the expected result
  task automatic predict_step(logic op, logic [IN_DATA_W-1:0] data);
    step_t e;
    vec_t  p, d;
    bit    enc;
    e = '0;
    enc = 0;
    if (op == OP_CLEAR) begin
      empty_simplex();
    end else begin
      p.x = $signed(data[15:0]);
      p.y = $signed(data[31:16]);
      p.z = $signed(data[47:32]);
      d.x = $signed(data[101:48]);
      d.y = $signed(data[155:102]);
      d.z = $signed(data[209:156]);
      for (int i = 3; i > 0; i--) begin
        sx[i] = sx[i-1]; sy[i] = sy[i-1]; sz[i] = sz[i-1];
      end
      store(0, p);
      if (npts < 4) npts = npts + 1;
      case (npts)
        3'd2: line_case(d);
        3'd3: triangle_case(d);
        3'd4: tetra_case(enc, d);
        default: ;
      endcase
      e.enclosed = enc;
      e.dx = clamp_dir(d.x);
      e.dy = clamp_dir(d.y);
      e.dz = clamp_dir(d.z);
      e.cnt = npts;
    end
    step_q.push_back(e);
  endtask

  initial begin
    fail_count = 0;
    empty_simplex();
  end

  // compare the oldest expectation first, then take in the new request
  always @(posedge clk) begin
    step_t e;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (step_q.size() == 0) begin
          $error("result with no request waiting");
          fail_count++;
        end else begin
          e = step_q.pop_front();
          if (m_axis_tuser !== e.enclosed) begin
            $error("contains_origin exp %0d got %0d", e.enclosed, m_axis_tuser);
            fail_count++;
          end
          if (m_axis_tdata[53:0] !== e.dx) begin
            $error("next_dir_x exp %h got %h", e.dx, m_axis_tdata[53:0]);
            fail_count++;
          end
          if (m_axis_tdata[107:54] !== e.dy) begin
            $error("next_dir_y exp %h got %h", e.dy, m_axis_tdata[107:54]);
            fail_count++;
          end
          if (m_axis_tdata[161:108] !== e.dz) begin
            $error("next_dir_z exp %h got %h", e.dz, m_axis_tdata[161:108]);
            fail_count++;
          end
          if (m_axis_tdata[164:162] !== e.cnt) begin
            $error("simplex_count exp %0d got %0d", e.cnt, m_axis_tdata[164:162]);
            fail_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) predict_step(s_axis_tuser, s_axis_tdata);
    end
  end

endmodule

/* dv/tb.sv */
// Testbench top for the GJK simplex update block: stimulus, sink and verdict.
`timescale 1ns / 1ps

module tb;
  import gjk_pkg::*;

  logic                  clk = 0;
  logic                  rst = 1;
  logic                  s_axis_tvalid = 0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = OP_CLEAR;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  int                    fail_count;
  int                    pending;
  int                    sent = 0;
  bit                    quiet = 0;
  bit                    hold_req = 0;
  bit                    hold_done = 0;

  always #5 clk = ~clk;

  gjk_simplex_update dut (.*);

  gjk_simplex_update_chk chk (.*);

  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      2: return 16'h0000;
      default: return 16'($urandom_range(0, 1200) - 600);
    endcase
  endfunction

  function automatic logic [53:0] pick_dir();
    logic [53:0] v;
    case ($urandom_range(0, 7))
      0: v = 54'd1 << 52;
      1: v = -(54'd1 << 52);
      default: begin
        v = {2'b00, 20'($urandom), 32'($urandom)};
        if ($urandom_range(0, 1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // offer one request, with an optional idle burst in front
  task automatic send(logic op, logic [15:0] px, logic [15:0] py, logic [15:0] pz);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      s_axis_tvalid = 0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1;
    s_axis_tuser  = op;
    s_axis_tdata  = {6'b0, pick_dir(), pick_dir(), pick_dir(), pz, py, px};
    while (!s_axis_tready) @(negedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic push_rand();
    send(OP_PUSH, pick_coord(), pick_coord(), pick_coord());
  endtask

  // sink with random stall bursts and one long hold-off
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        m_axis_tready = 0;
        repeat (400) @(negedge clk);
        hold_done = 1;
      end
      if (!quiet && $urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 14);
        m_axis_tready = 0;
        repeat (n - 1) @(negedge clk);
      end else begin
        m_axis_tready = 1;
      end
    end
  end

  initial begin
    #10ms;
    $display("gjk_simplex_update regression: fail");
    $finish;
  end

  initial begin
    int n;
    repeat (4) @(negedge clk);
    rst = 0;
    // directed: clear, extremes, zeros, a tetrahedron around the origin
    send(OP_CLEAR, 16'h0, 16'h0, 16'h0);
    send(OP_PUSH, 16'h7fff, 16'h7fff, 16'h7fff);
    send(OP_PUSH, 16'h8000, 16'h8000, 16'h8000);
    send(OP_PUSH, 16'h7fff, 16'h8000, 16'h7fff);
    send(OP_PUSH, 16'h8000, 16'h7fff, 16'h8000);
    send(OP_PUSH, 16'h0, 16'h0, 16'h0);
    send(OP_CLEAR, 16'hffff, 16'hffff, 16'hffff);
    send(OP_PUSH, 16'h0, 16'h0, 16'h0);
    send(OP_PUSH, 16'h0, 16'h0, 16'h0);
    send(OP_PUSH, 16'h0, 16'h0, 16'h0);
    send(OP_PUSH, 16'h0, 16'h0, 16'h0);
    send(OP_CLEAR, 16'h0, 16'h0, 16'h0);
    send(OP_PUSH, 16'd256, 16'd256, 16'd256);
    send(OP_PUSH, -16'sd256, 16'd256, -16'sd256);
    send(OP_PUSH, 16'd256, -16'sd256, -16'sd256);
    send(OP_PUSH, -16'sd256, -16'sd256, 16'd256);
    send(OP_PUSH, 16'd100, 16'd0, 16'd0);
    send(OP_CLEAR, 16'h0, 16'h0, 16'h0);
    send(OP_PUSH, 16'd300, 16'd0, 16'd0);
    send(OP_PUSH, -16'sd300, 16'd0, 16'd0);
    // random: runs of pushes between clears
    while (sent < 1870) begin
      if (sent > 600 && !hold_req) hold_req = 1;
      if (sent > 1700) quiet = 1;
      if ($urandom_range(0, 5) != 0) send(OP_CLEAR, pick_coord(), pick_coord(), pick_coord());
      n = $urandom_range(1, 9);
      repeat (n) push_rand();
    end
    s_axis_tvalid = 0;
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (fail_count == 0) begin
      $display("gjk_simplex_update regression: pass");
    end else begin
      $display("gjk_simplex_update regression: fail");
    end
    $finish;
  end

endmodule
